### hw/rtl/partition_block_range_mapper_core_defines.svh
// Assertion macros used by the partition block range mapper RTL.
`ifndef PARTITION_BLOCK_RANGE_MAPPER_CORE_DEFINES_SVH
`define PARTITION_BLOCK_RANGE_MAPPER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PBRM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("pbrm assertion failed");
`define PBRM_ASSERT_NEVER(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
    else $error("pbrm forbidden condition seen");
`else
`define PBRM_ASSERT(lbl, clk, rstn, prop)
`define PBRM_ASSERT_NEVER(lbl, clk, rstn, prop)
`endif
`endif

### hw/rtl/pbrm_pkg.sv
// Types and constants of the partition block range mapper.
package pbrm_pkg;

  localparam int NumPartitions = 8;
  localparam int IdxW          = $clog2(NumPartitions);
  localparam int CntW          = $clog2(NumPartitions + 1);
  localparam int BlockBytes    = 512;
  localparam int BlockShift    = $clog2(BlockBytes);
  localparam int BlkW          = 32;
  localparam int OfsW          = 64;
  localparam int InDataW       = 136;
  localparam int OutDataW      = 104;
  localparam int UserW         = 2;

  localparam logic [1:0] CmdAdd   = 2'd0;
  localparam logic [1:0] CmdRead  = 2'd1;
  localparam logic [1:0] CmdWrite = 2'd2;

  localparam logic [1:0] KindMapped = 2'd0;
  localparam logic [1:0] KindGap    = 2'd1;
  localparam logic [1:0] KindStatus = 2'd2;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StBeyond   = 2'd1;
  localparam logic [1:0] StReadOnly = 2'd2;
  localparam logic [1:0] StFull     = 2'd3;

  typedef struct packed {
    logic [BlkW-1:0] first;
    logic [BlkW-1:0] length;
    logic [OfsW-1:0] byte_start;
    logic            read_only;
  } entry_t;

  typedef struct packed {
    logic covers;
    logic above;
    logic closer;
  } cmp_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [IdxW-1:0] idx;
    logic [OfsW-1:0] ofs;
    logic [BlkW-1:0] blocks;
    logic [1:0]      status;
    logic            last;
  } res_t;

endpackage

### hw/rtl/partition_block_range_mapper_core.sv
// Top level of the partition block range mapper.
//
// Input transactions arrive on s_axis: tuser carries the command (add entry,
// read or write) and tdata the block range, the byte start and the read-only
// flag. An add writes the next partition table entry. A read or write is
// checked against total_blocks, set through cfg_we_i/cfg_wdata_i, which the
// user must write only while idle (not enforced by the block), and is then
// split into mapped and gap runs that leave on m_axis, one transaction per
// run, with tlast on the final result of the request. Each input transaction
// takes the block out of ready until its last result has been handed to the
// output register. Each is accepted in SIdle and checked in SCheck; an add,
// a range error or an empty request then goes to SEmit. Each run of a read
// or write takes a scan of the partition table through its single read
// port, one entry per cycle with the shared compare unit, which stops at the
// first covering entry; the run is formed in SCalc1 (and SCalc2 if mapped)
// and handed over in SEmit. A request yields at most 2 * NumPartitions + 1
// results. Reset empties the table and clears total_blocks. When m_axis
// stalls, the output register holds its result and the sequencer waits
// before the next one; a new input can be taken while the last result waits.
`include "partition_block_range_mapper_core_defines.svh"

module partition_block_range_mapper_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pbrm_pkg::BlkW-1:0]    cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // first_block, block_count, byte_start, read_only, zero pad
  input  logic [pbrm_pkg::InDataW-1:0] s_axis_tdata,
  // command
  input  logic [pbrm_pkg::UserW-1:0]   s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // partition_index, byte_offset, run_blocks, status, zero pad
  output logic [pbrm_pkg::OutDataW-1:0] m_axis_tdata,
  // run_kind
  output logic [pbrm_pkg::UserW-1:0]   m_axis_tuser,
  output logic                         m_axis_tlast
);
  import pbrm_pkg::*;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SCheck = 3'd1;
  localparam logic [2:0] SScan  = 3'd2;
  localparam logic [2:0] SCalc1 = 3'd3;
  localparam logic [2:0] SCalc2 = 3'd4;
  localparam logic [2:0] SEmit  = 3'd5;

  logic [2:0]      state_q, state_d;
  logic [BlkW-1:0] total_q;
  logic [CntW-1:0] count_q, count_d;
  logic [1:0]      cmd_q, cmd_d;
  logic [BlkW-1:0] blk_q, blk_d;
  logic [BlkW-1:0] n_q, n_d;
  entry_t          new_q, new_d;
  logic [CntW-1:0] scan_q, scan_d;
  logic            rd_vld_q, rd_vld_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic            hit_q, hit_d;
  logic [IdxW-1:0] hit_idx_q, hit_idx_d;
  entry_t          hit_ent_q, hit_ent_d;
  logic            abv_q, abv_d;
  logic [BlkW-1:0] abv_first_q, abv_first_d;
  logic [BlkW-1:0] j_q, j_d;
  res_t            res_q, res_d;
  res_t            out_q, out_d;
  logic            out_valid_q, out_valid_d;

  logic            tbl_we;
  entry_t          rd_ent;
  cmp_t            cmp;
  logic            issue;
  logic            found;
  logic [BlkW:0]   range_end;
  logic [BlkW-1:0] m_gap;
  logic [BlkW-1:0] m_map;

  pbrm_table u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (new_q),
    .raddr_i (scan_q[IdxW-1:0]),
    .rdata_o (rd_ent)
  );

  pbrm_cmp u_cmp (
    .blk_i       (blk_q),
    .entry_i     (rd_ent),
    .abv_valid_i (abv_q),
    .abv_first_i (abv_first_q),
    .cmp_o       (cmp)
  );

  assign range_end = {1'b0, blk_q} + {1'b0, n_q};
  assign m_gap     = abv_first_q - blk_q;
  assign m_map     = hit_ent_q.length - j_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cmd_d       = cmd_q;
    blk_d       = blk_q;
    n_d         = n_q;
    new_d       = new_q;
    scan_d      = scan_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    hit_ent_d   = hit_ent_q;
    abv_d       = abv_q;
    abv_first_d = abv_first_q;
    j_d         = j_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    tbl_we      = 1'b0;
    issue       = 1'b0;
    found       = 1'b0;

    unique case (state_q)
      SIdle: begin
        if (s_axis_tvalid) begin
          cmd_d            = s_axis_tuser;
          blk_d            = s_axis_tdata[31:0];
          n_d              = s_axis_tdata[63:32];
          new_d.first      = s_axis_tdata[31:0];
          new_d.length     = s_axis_tdata[63:32];
          new_d.byte_start = s_axis_tdata[127:64];
          new_d.read_only  = s_axis_tdata[128];
          state_d          = SCheck;
        end
      end
      SCheck: begin
        res_d        = '0;
        res_d.kind   = KindStatus;
        res_d.status = StOk;
        res_d.last   = 1'b1;
        state_d      = SEmit;
        unique case (cmd_q) inside
          CmdAdd: begin
            if (count_q >= CntW'(NumPartitions)) begin
              res_d.status = StFull;
            end else begin
              tbl_we  = 1'b1;
              count_d = count_q + 1'b1;
            end
          end
          CmdRead, CmdWrite: begin
            if (range_end > {1'b0, total_q}) begin
              res_d.status = StBeyond;
            end else if (n_q != '0) begin
              scan_d  = '0;
              hit_d   = 1'b0;
              abv_d   = 1'b0;
              state_d = SScan;
            end
          end
          default: begin
          end
        endcase
      end
      SScan: begin
        if (rd_vld_q) begin
          if (cmp.covers) begin
            found     = 1'b1;
            hit_d     = 1'b1;
            hit_idx_d = rd_idx_q;
            hit_ent_d = rd_ent;
          end else if (cmp.closer) begin
            abv_d       = 1'b1;
            abv_first_d = rd_ent.first;
          end
        end
        issue = !found && (scan_q < count_q);
        if (issue) begin
          rd_vld_d = 1'b1;
          rd_idx_d = scan_q[IdxW-1:0];
          scan_d   = scan_q + 1'b1;
        end else begin
          state_d = SCalc1;
        end
      end
      SCalc1: begin
        res_d = '0;
        if (hit_q) begin
          if (cmd_q == CmdWrite && hit_ent_q.read_only) begin
            res_d.kind   = KindStatus;
            res_d.status = StReadOnly;
            res_d.last   = 1'b1;
            state_d      = SEmit;
          end else begin
            j_d     = blk_q - hit_ent_q.first;
            state_d = SCalc2;
          end
        end else if (abv_q) begin
          res_d.kind   = KindGap;
          res_d.blocks = (m_gap < n_q) ? m_gap : n_q;
          res_d.last   = (m_gap >= n_q);
          state_d      = SEmit;
        end else begin
          res_d.kind   = KindGap;
          res_d.blocks = n_q;
          res_d.last   = 1'b1;
          state_d      = SEmit;
        end
      end
      SCalc2: begin
        res_d        = '0;
        res_d.kind   = KindMapped;
        res_d.idx    = hit_idx_q;
        res_d.ofs    = hit_ent_q.byte_start
                     + {{(OfsW-BlkW-BlockShift){1'b0}}, j_q, {BlockShift{1'b0}}};
        res_d.blocks = (m_map < n_q) ? m_map : n_q;
        res_d.last   = (m_map >= n_q);
        state_d      = SEmit;
      end
      SEmit: begin
        if (!out_valid_q || m_axis_tready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          blk_d       = blk_q + res_q.blocks;
          n_d         = n_q - res_q.blocks;
          if (res_q.last) begin
            state_d = SIdle;
          end else begin
            scan_d  = '0;
            hit_d   = 1'b0;
            abv_d   = 1'b0;
            state_d = SScan;
          end
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      total_q     <= '0;
      count_q     <= '0;
      scan_q      <= '0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      abv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      rd_vld_q    <= rd_vld_d;
      hit_q       <= hit_d;
      abv_q       <= abv_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        total_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    blk_q       <= blk_d;
    n_q         <= n_d;
    new_q       <= new_d;
    rd_idx_q    <= rd_idx_d;
    hit_idx_q   <= hit_idx_d;
    hit_ent_q   <= hit_ent_d;
    abv_first_q <= abv_first_d;
    j_q         <= j_d;
    res_q       <= res_d;
    out_q       <= out_d;
  end

  assign s_axis_tready = (state_q == SIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {3'b000, out_q.status, out_q.blocks, out_q.ofs, out_q.idx};

  `PBRM_ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > CntW'(NumPartitions))
  `PBRM_ASSERT(a_scan_bound, clk_i, rst_ni, state_q == SScan |-> scan_q <= count_q)
  `PBRM_ASSERT(a_run_nonempty, clk_i, rst_ni,
               out_valid_q && out_q.kind != KindStatus |->
               out_q.blocks != '0 && out_q.status == StOk)
  `PBRM_ASSERT(a_idle_after_last, clk_i, rst_ni,
               state_q == SEmit && res_q.last && (!out_valid_q || m_axis_tready) |=>
               state_q == SIdle)

endmodule

### hw/rtl/pbrm_table.sv
// Partition table memory with one write port and one registered read port.
module pbrm_table (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [pbrm_pkg::IdxW-1:0] waddr_i,
  input  pbrm_pkg::entry_t         wdata_i,
  input  logic [pbrm_pkg::IdxW-1:0] raddr_i,
  output pbrm_pkg::entry_t         rdata_o
);
  import pbrm_pkg::*;

  entry_t mem_q [NumPartitions];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/pbrm_cmp.sv
// Shared compare unit that classifies one table entry against a block number.
module pbrm_cmp (
  input  logic [pbrm_pkg::BlkW-1:0] blk_i,
  input  pbrm_pkg::entry_t          entry_i,
  input  logic                      abv_valid_i,
  input  logic [pbrm_pkg::BlkW-1:0] abv_first_i,
  output pbrm_pkg::cmp_t            cmp_o
);
  import pbrm_pkg::*;

  logic [BlkW:0] diff;

  assign diff = {1'b0, blk_i} - {1'b0, entry_i.first};

  always_comb begin
    cmp_o.above  = diff[BlkW];
    cmp_o.covers = !diff[BlkW] && (diff[BlkW-1:0] < entry_i.length);
    cmp_o.closer = diff[BlkW] && (!abv_valid_i || (entry_i.first < abv_first_i));
  end

endmodule

### dv/pbrm_checker.sv
// Checker for the partition block range mapper: predicts the runs of each request and compares them.
module pbrm_checker
  import pbrm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [BlkW-1:0]     cfg_wdata_i,
  input  logic                s_valid_i,
  input  logic                s_ready_i,
  input  logic [InDataW-1:0]  s_data_i,
  input  logic [UserW-1:0]    s_user_i,
  input  logic                m_valid_i,
  input  logic                m_ready_i,
  input  logic [OutDataW-1:0] m_data_i,
  input  logic [UserW-1:0]    m_user_i,
  input  logic                m_last_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  typedef enum logic [1:0] {
    FoundCover,
    FoundAbove,
    FoundNone
  } search_e;

  typedef struct packed {
    logic [6:0]      pad;
    logic            read_only;
    logic [OfsW-1:0] byte_start;
    logic [BlkW-1:0] block_count;
    logic [BlkW-1:0] first_block;
  } req_t;

  typedef struct packed {
    logic [2:0]      pad;
    logic [1:0]      status;
    logic [BlkW-1:0] blocks;
    logic [OfsW-1:0] ofs;
    logic [IdxW-1:0] idx;
  } run_t;

  entry_t          part_tbl[NumPartitions];
  logic [CntW-1:0] tbl_fill;
  logic [BlkW-1:0] disk_blocks;
  res_t            runs_due[$];
  int              mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic search_e find_partition(input logic [BlkW-1:0] blk, output int idx);
    bit have;
    int best;
    have = 1'b0;
    best = 0;
    idx  = 0;
    for (int i = 0; i < tbl_fill; i++) begin
      if (part_tbl[i].first <= blk) begin
        if (blk - part_tbl[i].first < part_tbl[i].length) begin
          idx = i;
          return FoundCover;
        end
      end else if (!have || part_tbl[i].first < part_tbl[best].first) begin
        have = 1'b1;
        best = i;
      end
    end
    if (have) begin
      idx = best;
      return FoundAbove;
    end
    return FoundNone;
  endfunction

  function automatic void add_run(logic [1:0] kind, int idx, logic [OfsW-1:0] ofs,
                                  logic [BlkW-1:0] blocks, logic [1:0] status);
    res_t r;
    r.kind   = kind;
    r.idx    = IdxW'(idx);
    r.ofs    = ofs;
    r.blocks = blocks;
    r.status = status;
    r.last   = 1'b0;
    runs_due.push_back(r);
  endfunction

  function automatic void map_request(logic [1:0] cmd, req_t req);
    logic [BlkW-1:0] blk, left, off, step;
    int              p;
    search_e         hit;
    bit              done;
    int              base;
    base = runs_due.size();
    step = '0;
    case (cmd) inside
      CmdAdd: begin
        if (tbl_fill >= NumPartitions) begin
          add_run(KindStatus, 0, '0, '0, StFull);
        end else begin
          part_tbl[tbl_fill] = '{first: req.first_block, length: req.block_count,
                                 byte_start: req.byte_start, read_only: req.read_only};
          tbl_fill++;
          add_run(KindStatus, 0, '0, '0, StOk);
        end
      end
      CmdRead, CmdWrite: begin
        if ({1'b0, req.first_block} + {1'b0, req.block_count} > {1'b0, disk_blocks}) begin
          add_run(KindStatus, 0, '0, '0, StBeyond);
        end else begin
          blk  = req.first_block;
          left = req.block_count;
          done = 1'b0;
          while (left != 0 && !done) begin
            hit = find_partition(blk, p);
            case (hit)
              FoundCover: begin
                off = blk - part_tbl[p].first;
                if (cmd == CmdWrite && part_tbl[p].read_only) begin
                  add_run(KindStatus, 0, '0, '0, StReadOnly);
                  done = 1'b1;
                end else begin
                  step = part_tbl[p].length - off;
                  if (step > left) step = left;
                  add_run(KindMapped, p,
                          part_tbl[p].byte_start + (OfsW'(off) << BlockShift), step, StOk);
                end
              end
              FoundAbove: begin
                step = part_tbl[p].first - blk;
                if (step > left) step = left;
                add_run(KindGap, 0, '0, step, StOk);
              end
              default: begin
                add_run(KindGap, 0, '0, left, StOk);
                done = 1'b1;
              end
            endcase
            if (!done) begin
              blk  = blk + step;
              left = left - step;
            end
          end
        end
      end
      default: add_run(KindStatus, 0, '0, '0, StOk);
    endcase
    if (runs_due.size() == base) add_run(KindStatus, 0, '0, '0, StOk);
    runs_due[runs_due.size() - 1].last = 1'b1;
  endfunction

  function automatic void check_field(string name, logic [OfsW-1:0] want, logic [OfsW-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_run();
    res_t want;
    run_t got;
    got = m_data_i;
    if (runs_due.size() == 0) begin
      $error("unexpected result transaction: run_kind %0d, tdata 0x%0h", m_user_i, m_data_i);
      mismatches++;
    end else begin
      want = runs_due.pop_front();
      check_field("run_kind", OfsW'(want.kind), OfsW'(m_user_i));
      check_field("partition_index", OfsW'(want.idx), OfsW'(got.idx));
      check_field("byte_offset", want.ofs, got.ofs);
      check_field("run_blocks", OfsW'(want.blocks), OfsW'(got.blocks));
      check_field("status", OfsW'(want.status), OfsW'(got.status));
      check_field("last", OfsW'(want.last), OfsW'(m_last_i));
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disk_blocks = '0;
      tbl_fill    = '0;
      runs_due.delete();
    end else begin
      if (cfg_we_i) disk_blocks = cfg_wdata_i;
      if (m_valid_i && m_ready_i) check_run();
      if (s_valid_i && s_ready_i) map_request(s_user_i, req_t'(s_data_i));
    end
    pending_o = runs_due.size();
  end

endmodule

### dv/tb_partition_block_range_mapper_core.sv
// Testbench top for the partition block range mapper: clock, reset, stimulus and verdict.
module tb_partition_block_range_mapper_core;
  import pbrm_pkg::*;

  localparam logic [1:0] CmdNone = 2'd3;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [BlkW-1:0]     cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic [UserW-1:0]    s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [UserW-1:0]    m_axis_tuser;
  logic                m_axis_tlast;

  int fail_count;
  int pending;
  int send_idle  = 14;
  int recv_stall = 80;

  partition_block_range_mapper_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  pbrm_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_i    (s_axis_tready),
    .s_data_i     (s_axis_tdata),
    .s_user_i     (s_axis_tuser),
    .m_valid_i    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_data_i     (m_axis_tdata),
    .m_user_i     (m_axis_tuser),
    .m_last_i     (m_axis_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(99) >= recv_stall);
  end

  initial begin
    #40_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic logic [OfsW-1:0] rand_ofs();
    return {$urandom, $urandom};
  endfunction

  task automatic send(logic [1:0] cmd, logic [BlkW-1:0] first, logic [BlkW-1:0] count,
                      logic [OfsW-1:0] bstart, logic ro);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = cmd;
    s_axis_tdata  = {7'b0, ro, bstart, count, first};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic set_disk(logic [BlkW-1:0] blocks);
    wait_idle();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = blocks;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  task automatic send_random();
    int              pick;
    logic [1:0]      cmd;
    logic [BlkW-1:0] first, count;
    pick  = $urandom_range(99);
    cmd   = $urandom_range(1) ? CmdWrite : CmdRead;
    first = $urandom;
    count = $urandom;
    if (pick < 3) begin
      cmd = CmdAdd;
    end else if (pick < 5) begin
      cmd = CmdNone;
    end else if (pick < 75) begin
      first = $urandom_range(620);
      count = $urandom_range(320);
    end else if (pick < 88) begin
      first = 32'hffff_fe00 + $urandom_range(511);
      count = $urandom_range(512);
    end
    send(cmd, first, count, rand_ofs(), 1'($urandom));
  endtask

  initial begin
    logic [BlkW-1:0] disk;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    set_disk('0);
    send(CmdRead, 0, 0, '0, 1'b0);
    send(CmdWrite, 0, 1, '1, 1'b1);
    send(CmdAdd, 100, 50, '0, 1'b0);
    send(CmdAdd, 20, 30, 64'h1000, 1'b0);
    send(CmdAdd, 160, 20, '1, 1'b1);
    send(CmdAdd, 120, 50, rand_ofs(), 1'b0);
    send(CmdAdd, 300, 0, rand_ofs(), 1'b1);
    send(CmdAdd, 32'hffff_ff00, 32'h100, 64'hffff_ffff_ffff_f000, 1'b0);
    send(CmdAdd, 400, 8, rand_ofs(), 1'b1);
    send(CmdAdd, 210, 40, rand_ofs(), 1'b0);
    send(CmdAdd, '1, '1, '1, 1'b1);
    send(CmdNone, $urandom, $urandom, rand_ofs(), 1'b1);

    set_disk(600);
    send(CmdRead, 0, 600, '0, 1'b0);
    send(CmdWrite, 0, 600, '0, 1'b0);
    send(CmdWrite, 400, 8, '0, 1'b0);
    send(CmdWrite, 180, 100, '0, 1'b0);
    send(CmdRead, 599, 1, '0, 1'b0);
    send(CmdRead, 600, 0, '0, 1'b0);
    send(CmdRead, '1, 1, '0, 1'b0);
    send(CmdRead, 100, '1, '0, 1'b0);

    set_disk('1);
    send(CmdRead, 32'hffff_fff0, 15, '0, 1'b0);
    send(CmdRead, 0, '1, '0, 1'b0);
    send(CmdWrite, 32'hffff_fffe, 1, '0, 1'b0);
    send(CmdRead, '1, 0, '0, 1'b0);

    for (int phase = 0; phase < 6; phase++) begin
      case ($urandom_range(3))
        0:       disk = 600;
        1:       disk = '1;
        2:       disk = 450;
        default: disk = $urandom;
      endcase
      set_disk(disk);
      case (phase / 2)
        0: begin
          send_idle  = 14;
          recv_stall = 80;
        end
        1: begin
          send_idle  = 80;
          recv_stall = 14;
        end
        default: begin
          send_idle  = 0;
          recv_stall = 0;
        end
      endcase
      repeat (33) send_random();
    end

    wait_idle();
    repeat (40) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
